// ===== sv/cfc_pkg.sv =====
package cfc_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_FRAME = 2'd1;
  localparam logic [1:0] FUNC_ROW   = 2'd2;
  localparam logic [1:0] FUNC_BYTE  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_ROW_LIMIT    = 1'b0;
  localparam logic CFG_COLUMN_LIMIT = 1'b1;

  localparam int ROW_LIMIT_W    = 9;
  localparam int COLUMN_LIMIT_W = 10;
  localparam int CFG_DATA_W     = 10;

  localparam logic [ROW_LIMIT_W-1:0]    ROW_LIMIT_RESET    = 9'd60;
  localparam logic [COLUMN_LIMIT_W-1:0] COLUMN_LIMIT_RESET = 10'd80;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [18:0] pixel_index;
    logic [4:0]  red;
    logic [5:0]  green;
    logic [4:0]  blue;
    logic        capture_busy;
    logic [8:0]  rows_seen;
  } result_t;

endpackage

// ===== sv/cfc_in_stage.sv =====
module cfc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_func,
  input  logic [7:0]     in_data_byte,
  input  logic           advance,
  output logic           item_valid,
  output cfc_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  cfc_pkg::item_t item_r;
  logic           take;

  // Stall only while a held item cannot move on
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.func      <= in_func;
      item_r.data_byte <= in_data_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== sv/cfc_core.sv =====
module cfc_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  cfc_pkg::item_t                        item,
  input  logic [cfc_pkg::ROW_LIMIT_W-1:0]       row_limit,
  input  logic [cfc_pkg::COLUMN_LIMIT_W-1:0]    column_limit,
  output cfc_pkg::result_t                      result
);

  logic        request_pending_r, request_pending_nxt;
  logic        sampling_active_r, sampling_active_nxt;
  logic        row_open_r, row_open_nxt;
  logic [8:0]  row_cnt_r, row_cnt_nxt;
  logic [10:0] row_byte_cnt_r, row_byte_cnt_nxt;
  logic [19:0] frame_byte_cnt_r, frame_byte_cnt_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;

  logic [10:0] row_bytes;
  logic [18:0] frame_pixels;
  logic [19:0] frame_bytes;
  logic [8:0]  row_inc;
  logic [10:0] row_byte_inc;
  logic [19:0] frame_byte_inc;

  assign row_bytes      = {column_limit, 1'b0};
  assign frame_pixels   = {10'd0, row_limit} * {9'd0, column_limit};
  assign frame_bytes    = {frame_pixels, 1'b0};
  assign row_inc        = row_cnt_r + 9'd1;
  assign row_byte_inc   = row_byte_cnt_r + 11'd1;
  assign frame_byte_inc = frame_byte_cnt_r + 20'd1;

  always_comb begin
    request_pending_nxt = request_pending_r;
    sampling_active_nxt = sampling_active_r;
    row_open_nxt        = row_open_r;
    row_cnt_nxt         = row_cnt_r;
    row_byte_cnt_nxt    = row_byte_cnt_r;
    frame_byte_cnt_nxt  = frame_byte_cnt_r;
    held_byte_nxt       = held_byte_r;
    result              = '0;

    unique case (item.func)
      cfc_pkg::FUNC_START: begin
        request_pending_nxt = 1'b1;
      end
      cfc_pkg::FUNC_FRAME: begin
        // Restart counters; an open row stays open
        if (request_pending_r) begin
          row_cnt_nxt         = '0;
          row_byte_cnt_nxt    = '0;
          frame_byte_cnt_nxt  = '0;
          sampling_active_nxt = 1'b1;
        end
      end
      cfc_pkg::FUNC_ROW: begin
        if (request_pending_r && sampling_active_r) begin
          row_open_nxt = 1'b1;
          row_cnt_nxt  = row_inc;
          if (row_inc >= row_limit) begin
            sampling_active_nxt = 1'b0;
            request_pending_nxt = 1'b0;
            row_open_nxt        = 1'b0;
          end
        end
      end
      cfc_pkg::FUNC_BYTE: begin
        if (request_pending_r && sampling_active_r && row_open_r &&
            (row_byte_cnt_r < row_bytes)) begin
          if (!frame_byte_cnt_r[0]) begin
            held_byte_nxt = item.data_byte;
          end else begin
            result.pixel_valid = 1'b1;
            result.pixel_index = frame_byte_cnt_r[19:1];
            result.red         = held_byte_r[7:3];
            result.green       = {held_byte_r[2:0], item.data_byte[7:5]};
            result.blue        = item.data_byte[4:0];
          end
          frame_byte_cnt_nxt = frame_byte_inc;
          row_byte_cnt_nxt   = row_byte_inc;
          if (row_byte_inc == row_bytes) begin
            row_open_nxt     = 1'b0;
            row_byte_cnt_nxt = '0;
          end
          if (frame_byte_inc == frame_bytes) begin
            sampling_active_nxt = 1'b0;
            request_pending_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    result.capture_busy = request_pending_nxt || sampling_active_nxt;
    result.rows_seen    = row_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_pending_r <= 1'b0;
      sampling_active_r <= 1'b0;
      row_open_r        <= 1'b0;
      row_cnt_r         <= '0;
      row_byte_cnt_r    <= '0;
      frame_byte_cnt_r  <= '0;
      held_byte_r       <= '0;
    end else if (fire) begin
      request_pending_r <= request_pending_nxt;
      sampling_active_r <= sampling_active_nxt;
      row_open_r        <= row_open_nxt;
      row_cnt_r         <= row_cnt_nxt;
      row_byte_cnt_r    <= row_byte_cnt_nxt;
      frame_byte_cnt_r  <= frame_byte_cnt_nxt;
      held_byte_r       <= held_byte_nxt;
    end
  end

  a_sampling_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    sampling_active_r |-> request_pending_r)
    else $error("sampling active without a pending request");

  a_pixel_ends_even: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.pixel_valid |=> !frame_byte_cnt_r[0])
    else $error("frame byte count odd after a completed pixel");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.func == cfc_pkg::FUNC_FRAME) && request_pending_r
      |=> (frame_byte_cnt_r == '0) && sampling_active_r && (row_cnt_r == '0))
    else $error("frame sync did not restart the capture");

endmodule

// ===== sv/cfc_out_stage.sv =====
module cfc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cfc_pkg::result_t result,
  input  logic             out_stall,
  output logic             out_free,
  output logic             out_valid,
  output cfc_pkg::result_t out_result
);

  logic             valid_r;
  logic             valid_nxt;
  cfc_pkg::result_t result_r;

  // Room for a new result when empty or when the current one leaves now
  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ===== sv/camera_frame_capture_rgb565.sv =====
// Parallel camera bus capture with on-the-fly RGB565 unpacking.
// Input channel (in_valid / in_stall): one event per transfer, in_func selects
// start request, frame sync, row sync or byte strobe; in_data_byte carries the
// camera byte for a byte strobe. Every event yields exactly one result transfer.
// Result channel (out_valid / out_stall): out_pixel_valid marks a completed
// pixel with its index and 5/6/5 color fields (zero otherwise); out_capture_busy
// and out_rows_seen report the capture state after the event.
// Configuration (cfg_wr_en / cfg_index / cfg_data): row limit and column limit.
// They must be written only while the block is idle; the block does not enforce it.
// From an input transfer, the event waits in the input register, then passes
// through the event logic into the result register.
// One event per cycle while the receiver does not stall; the capture counters
// update as each event moves into the result register.
// Reset clears the capture state and loads row limit 60, column limit 80.
// A stalled receiver holds the result register; the input register still takes
// one more event if it is empty, then in_stall rises until the result moves on.
module camera_frame_capture_rgb565 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_pixel_valid,
  output logic [18:0]                        out_pixel_index,
  output logic [4:0]                         out_red,
  output logic [5:0]                         out_green,
  output logic [4:0]                         out_blue,
  output logic                               out_capture_busy,
  output logic [8:0]                         out_rows_seen,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [cfc_pkg::ROW_LIMIT_W-1:0]    row_limit_r;
  logic [cfc_pkg::COLUMN_LIMIT_W-1:0] column_limit_r;

  logic             item_valid;
  cfc_pkg::item_t   item;
  logic             out_free;
  logic             fire;
  cfc_pkg::result_t result;
  cfc_pkg::result_t out_result;

  // Configuration registers: plain write, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_limit_r    <= cfc_pkg::ROW_LIMIT_RESET;
      column_limit_r <= cfc_pkg::COLUMN_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cfc_pkg::CFG_ROW_LIMIT:    row_limit_r    <= cfg_data[cfc_pkg::ROW_LIMIT_W-1:0];
        cfc_pkg::CFG_COLUMN_LIMIT: column_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: hold one event until the result register has room
  cfc_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .advance      (out_free),
    .item_valid   (item_valid),
    .item         (item)
  );

  // Advance the capture state exactly when an event moves into the result register
  assign fire = item_valid && out_free;

  cfc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (item),
    .row_limit    (row_limit_r),
    .column_limit (column_limit_r),
    .result       (result)
  );

  cfc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .out_stall  (out_stall),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_pixel_valid  = out_result.pixel_valid;
  assign out_pixel_index  = out_result.pixel_index;
  assign out_red          = out_result.red;
  assign out_green        = out_result.green;
  assign out_blue         = out_result.blue;
  assign out_capture_busy = out_result.capture_busy;
  assign out_rows_seen    = out_result.rows_seen;

endmodule

// ===== sim/camera_frame_capture_rgb565_tb.sv =====
module camera_frame_capture_rgb565_tb;
  import cfc_pkg::*;

  // Cycles the receiver holds off in one long stretch
  localparam int LONG_HOLD = 60;

  // Predicts one result per event from its own copy of the capture state and
  // compares every result transfer against the oldest prediction.
  class capture_scoreboard;
    logic [8:0]  row_limit;
    logic [9:0]  column_limit;
    bit          request_pending;
    bit          sampling_active;
    bit          row_open;
    logic [8:0]  row_counter;
    logic [10:0] row_byte_counter;
    logic [19:0] frame_byte_counter;
    logic [7:0]  held_first_byte;
    result_t     predicted_results[$];
    int          errors;
    int          events_noted;
    int          results_checked;
    int          pixels_checked;
    int          row_limit_stops;
    int          byte_count_stops;

    function new();
      row_limit          = ROW_LIMIT_RESET;
      column_limit       = COLUMN_LIMIT_RESET;
      request_pending    = 1'b0;
      sampling_active    = 1'b0;
      row_open           = 1'b0;
      row_counter        = '0;
      row_byte_counter   = '0;
      frame_byte_counter = '0;
      held_first_byte    = '0;
      errors             = 0;
      events_noted       = 0;
      results_checked    = 0;
      pixels_checked     = 0;
      row_limit_stops    = 0;
      byte_count_stops   = 0;
    endfunction

    function void load_register(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_ROW_LIMIT) row_limit = value[ROW_LIMIT_W-1:0];
      else column_limit = value[COLUMN_LIMIT_W-1:0];
    endfunction

    function void end_capture();
      sampling_active = 1'b0;
      request_pending = 1'b0;
    endfunction

    function void note_event(item_t ev);
      result_t r;
      int      row_bytes;
      int      frame_bytes;
      r = '0;
      events_noted++;
      case (ev.func)
        FUNC_START: request_pending = 1'b1;
        FUNC_FRAME: begin
          // restart keeps row_open as it is
          if (request_pending) begin
            row_counter        = '0;
            row_byte_counter   = '0;
            frame_byte_counter = '0;
            sampling_active    = 1'b1;
          end
        end
        FUNC_ROW: begin
          if (request_pending && sampling_active) begin
            row_open    = 1'b1;
            row_counter = row_counter + 9'd1;
            if (row_counter >= row_limit) begin
              end_capture();
              row_open = 1'b0;
              row_limit_stops++;
            end
          end
        end
        default: begin
          row_bytes   = 2 * int'(column_limit);
          frame_bytes = int'(row_limit) * int'(column_limit) * 2;
          if (request_pending && sampling_active && row_open &&
              int'(row_byte_counter) < row_bytes) begin
            if (!frame_byte_counter[0]) begin
              held_first_byte = ev.data_byte;
            end else begin
              r.pixel_valid = 1'b1;
              r.pixel_index = frame_byte_counter[19:1];
              r.red         = held_first_byte[7:3];
              r.green       = {held_first_byte[2:0], ev.data_byte[7:5]};
              r.blue        = ev.data_byte[4:0];
            end
            frame_byte_counter = frame_byte_counter + 20'd1;
            row_byte_counter   = row_byte_counter + 11'd1;
            if (int'(row_byte_counter) == row_bytes) begin
              row_open         = 1'b0;
              row_byte_counter = '0;
            end
            if (int'(frame_byte_counter) == frame_bytes) begin
              end_capture();
              byte_count_stops++;
            end
          end
        end
      endcase
      r.capture_busy = request_pending || sampling_active;
      r.rows_seen    = row_counter;
      predicted_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_results.size() == 0) begin
        $error("result transfer with no prediction waiting (rows_seen %0d)", got.rows_seen);
        errors++;
        return;
      end
      want = predicted_results.pop_front();
      results_checked++;
      if (want.pixel_valid) pixels_checked++;
      compare_field("pixel_valid", want.pixel_valid, got.pixel_valid);
      compare_field("pixel_index", want.pixel_index, got.pixel_index);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("capture_busy", want.capture_busy, got.capture_busy);
      compare_field("rows_seen", want.rows_seen, got.rows_seen);
    endfunction

    function int outstanding();
      return predicted_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_func      = '0;
  logic [7:0]            in_data_byte = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  out_pixel_valid;
  logic [18:0]           out_pixel_index;
  logic [4:0]            out_red;
  logic [5:0]            out_green;
  logic [4:0]            out_blue;
  logic                  out_capture_busy;
  logic [8:0]            out_rows_seen;
  logic                  cfg_wr_en    = 1'b0;
  logic                  cfg_index    = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  capture_scoreboard sb;

  // Events waiting to be offered on the input channel
  item_t pending_events[$];
  int    events_queued  = 0;
  int    settings_used  = 0;

  // Sender burst / gap bookkeeping
  int    burst_left     = 0;
  int    gap_left       = 0;
  item_t accepted;
  item_t next_item;

  // Receiver stall pattern and long hold-off
  int    stall_mode     = 0;
  int    mode_left      = 0;
  int    stall_phase    = 0;
  int    hold_left      = 0;
  int    hold_requests  = 0;
  int    holds_served   = 0;

  result_t observed;

  camera_frame_capture_rgb565 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_index  (out_pixel_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_capture_busy (out_capture_busy),
    .out_rows_seen    (out_rows_seen),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses results.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Sender: offer queued events in bursts of random length separated by
  // random gaps. A stalled transfer keeps its payload until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      // Record the transfer that completes at this edge.
      if (in_valid && !in_stall) begin
        accepted.func      = in_func;
        accepted.data_byte = in_data_byte;
        sb.note_event(accepted);
      end
      // Hold a stalled transfer; otherwise advance.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_events.size() != 0) begin
          next_item     = pending_events.pop_front();
          in_valid     <= 1'b1;
          in_func      <= next_item.func;
          in_data_byte <= next_item.data_byte;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            // Close the burst: pick the next burst length and the gap before it.
            burst_left <= $urandom_range(1, 48);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left <= 0;
              3, 4, 5: gap_left <= $urandom_range(1, 3);
              6:       gap_left <= $urandom_range(4, 12);
              default: gap_left <= $urandom_range(13, 30);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a pattern that switches between free flow, light and
  // heavy random stalls and a fixed duty cycle. A long hold-off, when asked
  // for, is counted here so the sender keeps offering events meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      stall_mode   <= 0;
      mode_left    <= 0;
      stall_phase  <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
        out_stall    <= 1'b1;
        hold_left    <= LONG_HOLD - 1;
        holds_served <= holds_served + 1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 4) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ((stall_phase % 7) < 3);
        endcase
      end
      stall_phase <= stall_phase + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      observed.pixel_valid  = out_pixel_valid;
      observed.pixel_index  = out_pixel_index;
      observed.red          = out_red;
      observed.green        = out_green;
      observed.blue         = out_blue;
      observed.capture_busy = out_capture_busy;
      observed.rows_seen    = out_rows_seen;
      sb.check_result(observed);
    end
  end

  task automatic push_event(logic [1:0] func, logic [7:0] data_byte);
    item_t ev;
    ev.func      = func;
    ev.data_byte = data_byte;
    pending_events.push_back(ev);
    events_queued++;
  endtask

  task automatic push_noise();
    push_event($urandom_range(0, 3), $urandom_range(0, 255));
  endtask

  // Write one register; the block must be idle.
  task automatic set_register(logic idx, int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.load_register(idx, value[CFG_DATA_W-1:0]);
  endtask

  // Wait until every queued event has been taken and every result has come,
  // then let the pipeline empty out.
  task automatic settle();
    while (pending_events.size() != 0 || in_valid || sb.outstanding() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Queue one capture: request, frame sync, then rows of bytes. Most rows get
  // 2*cl bytes, capped at 12; some overrun or fall short, a few restart the
  // frame mid-row, and stray events are mixed in. Sparse captures send many
  // rows with almost no bytes so a large row limit can be reached quickly.
  task automatic queue_capture(int rl, int cl, bit sparse);
    int nrows;
    int full_row;
    int nbytes;
    if (sparse) nrows = rl + 1;
    else if (rl > 5) nrows = $urandom_range(1, 5);
    else nrows = rl + $urandom_range(0, 1);
    if (nrows == 0) nrows = 1;
    full_row = (cl > 6) ? 12 : 2 * cl;
    if ($urandom_range(0, 9) == 0) push_noise();
    push_event(FUNC_START, $urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) push_event(FUNC_START, $urandom_range(0, 255));
    push_event(FUNC_FRAME, $urandom_range(0, 255));
    for (int r = 0; r < nrows; r++) begin
      push_event(FUNC_ROW, $urandom_range(0, 255));
      if (sparse) begin
        nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4) : 0;
      end else begin
        nbytes = full_row;
        case ($urandom_range(0, 9))
          0:       nbytes = full_row + $urandom_range(1, 3);
          1:       nbytes = $urandom_range(0, full_row);
          default: nbytes = full_row;
        endcase
      end
      for (int b = 0; b < nbytes; b++) begin
        if (b > 0 && $urandom_range(0, 39) == 0)
          push_event(FUNC_FRAME, $urandom_range(0, 255));
        push_event(FUNC_BYTE, $urandom_range(0, 255));
      end
      if ($urandom_range(0, 24) == 0) push_noise();
    end
  endtask

  // One setting of the limits, entered from idle, with a budget of events.
  task automatic run_phase(int rl, int cl, int budget, bit sparse, bit long_hold);
    int start_count;
    settle();
    set_register(CFG_ROW_LIMIT, rl);
    set_register(CFG_COLUMN_LIMIT, cl);
    settings_used++;
    start_count = events_queued;
    while (events_queued - start_count < budget) queue_capture(rl, cl, sparse);
    if (long_hold) hold_requests++;
  endtask

  initial begin
    int rows_list[10];
    int cols_list[10];
    sb = new();
    rows_list = '{1, 3, 0, 4, 0, 5, 7, 2, 2, 6};
    cols_list = '{1, 2, 0, 0, 3, 3, 4, 5, 640, 1};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Captures at the reset limits; hold the receiver off once so the
    // block fills up and stalls its input.
    settings_used++;
    while (events_queued < 130) queue_capture(ROW_LIMIT_RESET, COLUMN_LIMIT_RESET, 1'b0);
    hold_requests++;
    settle();

    // Directed: events ignored while idle, repeated request, bytes before a
    // row opens, data extremes, a byte past the row end, row limit ending
    // the capture and rows_seen held afterwards.
    set_register(CFG_ROW_LIMIT, 2);
    set_register(CFG_COLUMN_LIMIT, 2);
    settings_used++;
    push_event(FUNC_ROW,   8'h00);
    push_event(FUNC_BYTE,  8'hA5);
    push_event(FUNC_FRAME, 8'hFF);
    push_event(FUNC_START, 8'h00);
    push_event(FUNC_START, 8'hFF);
    push_event(FUNC_BYTE,  8'h3C);
    push_event(FUNC_FRAME, 8'h00);
    push_event(FUNC_ROW,   8'h00);
    push_event(FUNC_BYTE,  8'h00);
    push_event(FUNC_BYTE,  8'hFF);
    push_event(FUNC_BYTE,  8'hFF);
    push_event(FUNC_BYTE,  8'h00);
    push_event(FUNC_BYTE,  8'h5A);
    push_event(FUNC_ROW,   8'hFF);
    push_event(FUNC_BYTE,  8'h81);
    push_event(FUNC_FRAME, 8'h7E);
    settle();

    // Directed: frame sync restarts the capture with the row still open, so
    // the byte count reaches its end before the row limit does.
    set_register(CFG_ROW_LIMIT, 2);
    set_register(CFG_COLUMN_LIMIT, 1);
    settings_used++;
    push_event(FUNC_START, 8'h00);
    push_event(FUNC_FRAME, 8'h00);
    push_event(FUNC_ROW,   8'h00);
    push_event(FUNC_BYTE,  8'h12);
    push_event(FUNC_FRAME, 8'h00);
    push_event(FUNC_BYTE,  8'hE7);
    push_event(FUNC_BYTE,  8'h18);
    push_event(FUNC_ROW,   8'h00);
    push_event(FUNC_BYTE,  8'hFF);
    push_event(FUNC_BYTE,  8'hFF);

    // Random captures over fixed settings, zero limits and a wide row among them.
    foreach (rows_list[i])
      run_phase(rows_list[i], cols_list[i], 80, 1'b0, i == 3);
    repeat (2) run_phase($urandom_range(1, 8), $urandom_range(0, 6), 80, 1'b0, 1'b0);

    // Limits of 480 rows and 640 columns: one capture that runs all the way to the row limit.
    run_phase(480, 640, 1, 1'b1, 1'b0);

    // Drain with a bound; whatever is still predicted after it is lost.
    for (int n = 0; n < 20000 &&
         (pending_events.size() != 0 || in_valid || sb.outstanding() != 0); n++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d predicted results never arrived", sb.outstanding());
      sb.errors++;
    end

    $display("Covered %0d events over %0d limit settings; %0d results checked, %0d pixels.",
             sb.events_noted, settings_used, sb.results_checked, sb.pixels_checked);
    $display("Captures ended %0d times on the row limit and %0d times on the byte count.",
             sb.row_limit_stops, sb.byte_count_stops);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== camera_frame_capture_rgb565.f =====
sv/cfc_pkg.sv
sv/cfc_in_stage.sv
sv/cfc_core.sv
sv/cfc_out_stage.sv
sv/camera_frame_capture_rgb565.sv
sim/camera_frame_capture_rgb565_tb.sv
